[sv/ggc_pkg.sv]
// Shared widths, field codes and defaults for the greedy graph coloring block.
package ggc_pkg;

    // Fixed field widths of the stream items
    localparam int KIND_W     = 2;
    localparam int VERTEX_W   = 6;
    localparam int ROW_W      = 64;
    localparam int COLOR_W    = 7;

    // Packed stream widths, padded to whole bytes
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 16;

    // Default graph size
    localparam int MAX_VERTICES_DEF = 64;

    // Item kinds carried in the input tuser
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_LOAD  = 2'd0;
    localparam t_kind KIND_COLOR = 2'd1;
    localparam t_kind KIND_EMIT  = 2'd2;

endpackage

[sv/ggc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module ggc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/greedy_graph_coloring.sv]
// Top level of the greedy graph coloring block: control, class scan and emit.
//
// Input stream (s_axis): tuser carries the item kind, tdata the vertex and an
// adjacency row. A load transfer writes one row into the adjacency RAM in the
// cycle it is taken. A color transfer reads the vertex's row and then walks
// the color class RAM from color 0 up, one class per cycle, until a class
// holds no neighbor; the vertex joins that class. An emit transfer walks the
// coloring order RAM once per color, one entry per cycle while no matching
// entry waits on a stalled output. Results leave on the output stream
// (m_axis) with tlast on the final one; afterwards every color is cleared.
// The output has a one-entry holding register: a stalled receiver stops the
// emit walk at a waiting matching entry, nothing is dropped. The input is
// ready only while no coloring scan or emit is in progress.
// Reset (synchronous, active low) clears all colors, counts and the output
// valid. Adjacency rows are undefined until loaded.
module greedy_graph_coloring
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // vertex[5:0], row_bits[69:6]
    input  logic [KIND_W-1:0]    i_s_axis_tuser,  // kind[1:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // out_vertex[5:0], out_color[12:6]
    output logic                 o_m_axis_tlast
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // Control registers
    logic [1:0]              r_state, n_state;
    logic [VW-1:0]           r_c, n_c;
    logic [VW-1:0]           r_i, n_i;
    logic [VW-1:0]           r_v, n_v;
    logic [CNTW-1:0]         r_count, n_count;
    logic [VW-1:0]           r_high, n_high;
    logic [VW-1:0]           r_last, n_last;
    logic [MAX_VERTICES-1:0] r_colored, n_colored;
    logic [MAX_VERTICES-1:0] r_cvalid, n_cvalid;
    logic [MAX_VERTICES-1:0] r_row, n_row;
    logic                    r_first, n_first;

    // Output holding register
    logic                    r_ovalid;
    logic [VERTEX_W-1:0]     r_out_vertex;
    logic [COLOR_W-1:0]      r_out_color;
    logic                    r_out_last;
    logic                    o_load;
    logic                    load_last;

    // RAM ports
    logic                    adj_we;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic                    cls_we;
    logic [MAX_VERTICES-1:0] cls_wdata, cls_rdata;
    logic                    ord_we;
    logic [2*VW-1:0]         ord_rdata;

    // Input fields
    logic                    accept;
    t_kind                   in_kind;
    logic [VERTEX_W-1:0]     in_vertex;
    logic [ROW_W-1:0]        in_row;
    logic                    v_ok;
    logic [VW-1:0]           v_idx;

    // Scan and emit helpers
    logic [MAX_VERTICES-1:0] row_cur;
    logic [MAX_VERTICES-1:0] members;
    logic                    hit;
    logic [VW-1:0]           e_v;
    logic [VW-1:0]           e_c;
    logic                    match;
    logic                    out_busy;
    logic                    pass_end;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_kind   = i_s_axis_tuser;
    assign in_vertex = i_s_axis_tdata[VERTEX_W-1:0];
    assign in_row    = i_s_axis_tdata[VERTEX_W+ROW_W-1:VERTEX_W];
    assign v_ok      = ({1'b0, in_vertex} < (VERTEX_W+1)'(MAX_VERTICES));
    assign v_idx     = in_vertex[VW-1:0];

    assign row_cur   = r_first ? adj_rdata : r_row;
    assign members   = r_cvalid[r_c] ? cls_rdata : '0;
    assign hit       = ((row_cur & members) == '0);
    assign cls_wdata = members | (MAX_VERTICES'(1) << r_v);

    assign e_v       = ord_rdata[VW-1:0];
    assign e_c       = ord_rdata[2*VW-1:VW];
    assign match     = (e_c == r_c);
    assign out_busy  = r_ovalid && !i_m_axis_tready;
    assign pass_end  = ((CNTW'(r_i) + CNTW'(1)) == r_count);
    assign load_last = (r_c == r_high) && (r_i == r_last);

    // Adjacency rows, one per vertex
    ggc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (v_idx),
        .i_wdata (in_row[MAX_VERTICES-1:0]),
        .i_raddr (v_idx),
        .o_rdata (adj_rdata)
    );

    // Color classes: member mask per color
    ggc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_cls_ram (
        .i_clk   (i_clk),
        .i_we    (cls_we),
        .i_waddr (r_c),
        .i_wdata (cls_wdata),
        .i_raddr (n_c),
        .o_rdata (cls_rdata)
    );

    // Coloring order: {color, vertex} per coloring step
    ggc_ram #(
        .WIDTH (2*VW),
        .DEPTH (MAX_VERTICES)
    ) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (r_count[VW-1:0]),
        .i_wdata ({r_c, r_v}),
        .i_raddr (n_i),
        .o_rdata (ord_rdata)
    );

    // Next-state logic for load, color scan and emit walk
    always_comb begin
        n_state   = r_state;
        n_c       = r_c;
        n_i       = r_i;
        n_v       = r_v;
        n_count   = r_count;
        n_high    = r_high;
        n_last    = r_last;
        n_colored = r_colored;
        n_cvalid  = r_cvalid;
        n_row     = r_row;
        n_first   = 1'b0;
        adj_we    = 1'b0;
        cls_we    = 1'b0;
        ord_we    = 1'b0;
        o_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_i = '0;
                if (accept) begin
                    case (in_kind)
                        KIND_LOAD: begin
                            adj_we = v_ok;
                        end
                        KIND_COLOR: begin
                            if (v_ok && !r_colored[v_idx]) begin
                                n_v     = v_idx;
                                n_c     = '0;
                                n_first = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        KIND_EMIT: begin
                            if (r_count != '0) begin
                                n_c     = '0;
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_row = row_cur;
                if (hit) begin
                    // Join this class and record the coloring step
                    cls_we          = 1'b1;
                    ord_we          = 1'b1;
                    n_colored[r_v]  = 1'b1;
                    n_cvalid[r_c]   = 1'b1;
                    n_count         = r_count + CNTW'(1);
                    if (r_c > r_high) begin
                        n_high = r_c;
                    end
                    if (r_c >= r_high) begin
                        n_last = r_count[VW-1:0];
                    end
                    n_state = S_IDLE;
                end else begin
                    n_c = r_c + VW'(1);
                end
            end
            S_EMIT: begin
                // Hold the walk while a matching entry waits for output space
                if (!(match && out_busy)) begin
                    o_load = match;
                    if (pass_end) begin
                        n_i = '0;
                        if (r_c == r_high) begin
                            n_count   = '0;
                            n_high    = '0;
                            n_colored = '0;
                            n_cvalid  = '0;
                            n_state   = S_IDLE;
                        end else begin
                            n_c = r_c + VW'(1);
                        end
                    end else begin
                        n_i = r_i + VW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_c       <= '0;
            r_i       <= '0;
            r_count   <= '0;
            r_high    <= '0;
            r_last    <= '0;
            r_colored <= '0;
            r_cvalid  <= '0;
            r_first   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_c       <= n_c;
            r_i       <= n_i;
            r_count   <= n_count;
            r_high    <= n_high;
            r_last    <= n_last;
            r_colored <= n_colored;
            r_cvalid  <= n_cvalid;
            r_first   <= n_first;
            if (o_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_row <= n_row;
        if (o_load) begin
            r_out_vertex <= VERTEX_W'(e_v);
            r_out_color  <= COLOR_W'(r_c) + COLOR_W'(1);
            r_out_last   <= load_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {(M_TDATA_W-VERTEX_W-COLOR_W)'(0), r_out_color, r_out_vertex};
    assign o_m_axis_tlast  = r_out_last;

endmodule
